>>> sv/rspe_pkg.sv
// shared types, constants and GF(2^8) arithmetic for the reed-solomon parity encoder
package rspe_pkg;

    // default and largest supported parity symbol count
    localparam int MAX_ECC_DEF   = 32;
    localparam int MAX_ECC_LIMIT = 64;
    localparam int CNT_W         = $clog2(MAX_ECC_LIMIT + 1);

    // configuration register widths
    localparam int ECC_W  = 6;
    localparam int ROOT_W = 8;
    localparam int POLY_W = 9;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ECC_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROOT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY = 2'd2;

    // configuration reset values
    localparam logic [ECC_W-1:0]  ECC_COUNT_RST  = 6'd16;
    localparam logic [ROOT_W-1:0] FIRST_ROOT_RST = 8'd0;
    localparam logic [POLY_W-1:0] FIELD_POLY_RST = 9'd285;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } rspe_in_t;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_parity;
        logic       last_out;
    } rspe_out_t;

    // effective settings seen by the generator builder and the encoder core
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [7:0]       first_root;
        logic [7:0]       red;
    } rspe_cfg_t;

    // multiply by alpha (x) modulo the field polynomial
    function automatic logic [7:0] gf_xtime(input logic [7:0] a, input logic [7:0] red);
        return a[7] ? ({a[6:0], 1'b0} ^ red) : {a[6:0], 1'b0};
    endfunction

    // shift-and-add GF(2^8) multiply, eight narrow steps
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] red);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = 8'd0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x, red);
        end
        return acc;
    endfunction

endpackage

>>> sv/rspe_gen_builder.sv
// iterative builder of the generator polynomial coefficients
module rspe_gen_builder import rspe_pkg::*; #(
    parameter int MAX_ECC = MAX_ECC_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  rspe_cfg_t              cfg,
    output logic                   busy,
    output logic [MAX_ECC-1:0][7:0] coeffs
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POW  = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [MAX_ECC-1:0][7:0] g_reg, g_next;
    logic [7:0]              r_reg, r_next;
    logic [7:0]              exp_reg, exp_next;
    logic [CNT_W-1:0]        len_reg, len_next;

    logic [7:0]              root_mod;
    logic [7:0]              exp_inc;
    logic [7:0]              r_inc;
    logic [MAX_ECC-1:0][7:0] g_step;

    // root exponent modulo 255 and the next power of alpha
    assign root_mod = (cfg.first_root == 8'd255) ? 8'd0 : cfg.first_root;
    assign exp_inc  = (exp_reg == 8'd254) ? 8'd0 : exp_reg + 8'd1;
    assign r_inc    = (exp_inc == 8'd0) ? 8'd1 : gf_xtime(r_reg, cfg.red);

    // multiply the generator by (x + r); the leading 1 is implicit
    always_comb begin
        g_step[0] = g_reg[0] ^ r_reg;
        for (int j = 1; j < MAX_ECC; j++) begin
            g_step[j] = g_reg[j] ^ gf_mul(g_reg[j-1], r_reg, cfg.red);
        end
    end

    // sequencer: power up alpha to the first root, then one root per cycle
    always_comb begin
        state_next = state_reg;
        g_next     = g_reg;
        r_next     = r_reg;
        exp_next   = exp_reg;
        len_next   = len_reg;
        if (start) begin
            state_next = ST_POW;
            g_next     = '0;
            r_next     = 8'd1;
            exp_next   = 8'd0;
            len_next   = '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                end
                ST_POW: begin
                    if (exp_reg == root_mod) begin
                        state_next = ST_STEP;
                    end else begin
                        r_next   = r_inc;
                        exp_next = exp_inc;
                    end
                end
                ST_STEP: begin
                    if (len_reg == cfg.n) begin
                        state_next = ST_IDLE;
                    end else begin
                        g_next   = g_step;
                        r_next   = r_inc;
                        exp_next = exp_inc;
                        len_next = len_reg + 1'b1;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // reset starts a build for the reset configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_POW;
            g_reg     <= '0;
            r_reg     <= 8'd1;
            exp_reg   <= 8'd0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            g_reg     <= g_next;
            r_reg     <= r_next;
            exp_reg   <= exp_next;
            len_reg   <= len_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign coeffs = g_reg;

endmodule

>>> sv/rspe_encoder_core.sv
// parity lfsr, parity drain and result register
module rspe_encoder_core import rspe_pkg::*; #(
    parameter int MAX_ECC = MAX_ECC_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rspe_cfg_t               cfg,
    input  logic                    gen_busy,
    input  logic [MAX_ECC-1:0][7:0] coeffs,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  rspe_in_t                s_payload,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rspe_out_t               m_payload
);

    logic [MAX_ECC-1:0][7:0] parity_reg, parity_next;
    logic [CNT_W-1:0]        drain_reg, drain_next;
    logic                    m_valid_reg, m_valid_next;
    rspe_out_t               m_item_reg, m_item_next;

    logic                    out_free;
    logic                    s_accept;
    logic [7:0]              fb;
    logic [MAX_ECC-1:0][7:0] shifted;
    logic [MAX_ECC-1:0][7:0] upd;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !gen_busy && (drain_reg == '0) && out_free;
    assign s_accept = s_valid && s_ready;

    // parity register moved one place toward the oldest symbol
    always_comb begin
        shifted[MAX_ECC-1] = 8'd0;
        for (int k = 0; k < MAX_ECC - 1; k++) begin
            shifted[k] = parity_reg[k+1];
        end
    end

    // parallel lfsr update for one message byte
    assign fb = s_payload.data_byte ^ parity_reg[0];
    always_comb begin
        for (int k = 0; k < MAX_ECC; k++) begin
            upd[k] = (((k + 1) < int'(cfg.n)) ? shifted[k] : 8'd0)
                     ^ gf_mul(coeffs[k], fb, cfg.red);
        end
    end

    // accept a byte, or send the next parity byte, or let the result go
    always_comb begin
        parity_next  = parity_reg;
        drain_next   = drain_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (s_accept) begin
            for (int k = 0; k < MAX_ECC; k++) begin
                if (k < int'(cfg.n)) begin
                    parity_next[k] = upd[k];
                end else if (s_payload.end_of_message) begin
                    parity_next[k] = 8'd0;
                end
            end
            drain_next             = s_payload.end_of_message ? cfg.n : '0;
            m_valid_next           = 1'b1;
            m_item_next.out_byte   = s_payload.data_byte;
            m_item_next.is_parity  = 1'b0;
            m_item_next.last_out   = s_payload.end_of_message && (cfg.n == '0);
        end else if ((drain_reg != '0) && out_free) begin
            parity_next            = shifted;
            drain_next             = drain_reg - 1'b1;
            m_valid_next           = 1'b1;
            m_item_next.out_byte   = parity_reg[0];
            m_item_next.is_parity  = 1'b1;
            m_item_next.last_out   = (drain_reg == CNT_W'(1));
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg  <= '0;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            parity_reg  <= parity_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_item_reg;

endmodule

>>> sv/reed_solomon_parity_encoder_top.sv
// top level of the systematic reed-solomon parity encoder over GF(2^8)
// Systematic Reed-Solomon encoder over GF(2^8): message bytes pass through one per cycle
// when not stalled, and the item that ends a message is followed by n parity bytes, oldest
// first, with last_out on the final one (n = ecc_count limited to MAX_ECC; n = 0 is plain
// pass-through). Within a message a byte is accepted every cycle unless the result
// register is full with m_ready low or the generator is being rebuilt; the parity
// register is updated by a parallel LFSR with one GF multiplier per tap. After the item
// ending a message the input stalls while the parity bytes leave through the single
// result register. After reset and after every write to a known configuration register
// the generator is rebuilt one root per cycle, input stalled; cfg writes are always taken.
module reed_solomon_parity_encoder_top import rspe_pkg::*; #(
    parameter int MAX_ECC = MAX_ECC_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rspe_in_t             s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rspe_out_t            m_payload,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POLY_W-1:0]    cfg_data
);

    logic [ECC_W-1:0]  ecc_count_reg, ecc_count_next;
    logic [ROOT_W-1:0] first_root_reg, first_root_next;
    logic [7:0]        red_reg, red_next;

    logic                    cfg_write;
    logic                    gen_start;
    logic                    gen_busy;
    rspe_cfg_t               cfg;
    logic [MAX_ECC-1:0][7:0] coeffs;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // configuration register decode; unknown indexes are dropped
    always_comb begin
        ecc_count_next  = ecc_count_reg;
        first_root_next = first_root_reg;
        red_next        = red_reg;
        gen_start       = 1'b0;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_ECC_COUNT: begin
                    ecc_count_next = cfg_data[ECC_W-1:0];
                    gen_start      = 1'b1;
                end
                CFG_FIRST_ROOT: begin
                    first_root_next = cfg_data[ROOT_W-1:0];
                    gen_start       = 1'b1;
                end
                CFG_FIELD_POLY: begin
                    red_next  = cfg_data[7:0];
                    gen_start = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecc_count_reg  <= ECC_COUNT_RST;
            first_root_reg <= FIRST_ROOT_RST;
            red_reg        <= FIELD_POLY_RST[7:0];
        end else begin
            ecc_count_reg  <= ecc_count_next;
            first_root_reg <= first_root_next;
            red_reg        <= red_next;
        end
    end

    // effective settings, parity count saturated at MAX_ECC
    assign cfg.n          = (int'(ecc_count_reg) > MAX_ECC) ? CNT_W'(MAX_ECC)
                                                            : CNT_W'(ecc_count_reg);
    assign cfg.first_root = first_root_reg;
    assign cfg.red        = red_reg;

    rspe_gen_builder #(
        .MAX_ECC (MAX_ECC)
    ) u_gen_builder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gen_start),
        .cfg     (cfg),
        .busy    (gen_busy),
        .coeffs  (coeffs)
    );

    rspe_encoder_core #(
        .MAX_ECC (MAX_ECC)
    ) u_encoder_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .gen_busy  (gen_busy),
        .coeffs    (coeffs),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // no item is taken while the generator is being rebuilt
    assert property (@(posedge aclk) disable iff (!aresetn)
        gen_busy |-> !s_ready)
        else $error("item accepted during generator rebuild");

    // a write to a known configuration register stalls the input on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        gen_start |=> !s_ready)
        else $error("input not stalled after configuration write");

    // an ending item with parity to send stalls the input for the drain
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.end_of_message && (cfg.n != '0)) |=> !s_ready)
        else $error("input not stalled during parity drain");

endmodule

>>> tb/sv/tb_reed_solomon_parity_encoder_top.sv
// testbench for the reed-solomon parity encoder with a GF(2^8) lfsr predictor
`timescale 1ns / 100ps

module tb_reed_solomon_parity_encoder_top;
    import rspe_pkg::*;

    localparam int MAX_ECC = MAX_ECC_DEF;
    localparam int RANDOM_SYMBOLS = 380;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_PCT = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {CMD_SYMBOL, CMD_WRITE, CMD_DRAIN} cmd_kind_t;

    typedef struct {
        cmd_kind_t            kind;
        rspe_in_t             sym;
        logic [CFG_IDX_W-1:0] idx;
        logic [POLY_W-1:0]    data;
        logic                 steady;
    } cmd_t;

    // block ports
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    rspe_in_t             s_payload = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    rspe_out_t            m_payload;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POLY_W-1:0]    cfg_data = '0;

    // stimulus and expected codeword symbols
    cmd_t      cmd_q[$];
    rspe_out_t codeword_q[$];
    logic      steady_now = 1'b0;
    int        settle_cnt = 0;

    // predictor state
    logic [ECC_W-1:0]  ecc_cfg;
    logic [ROOT_W-1:0] root_cfg;
    logic [POLY_W-1:0] poly_cfg;
    logic [7:0]        parity_sr [0:MAX_ECC-1];
    logic [7:0]        gen_taps [0:MAX_ECC-1];

    // bookkeeping
    int mismatch_cnt = 0;
    int results_checked = 0;
    int parity_checked = 0;
    int messages_done = 0;
    int symbols_sent = 0;
    int writes_done = 0;
    int symbols_queued = 0;

    reed_solomon_parity_encoder_top #(.MAX_ECC(MAX_ECC)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // field multiply, bits of b taken from the low end
    function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] red);
        logic [7:0] prod;
        logic [7:0] sh;
        logic [7:0] m;
        prod = 8'd0;
        sh   = a;
        m    = b;
        while (m != 8'd0) begin
            if (m[0]) begin
                prod = prod ^ sh;
            end
            sh = sh[7] ? ({sh[6:0], 1'b0} ^ red) : {sh[6:0], 1'b0};
            m  = m >> 1;
        end
        return prod;
    endfunction

    // alpha = 2 raised to e, exponent taken modulo 255
    function automatic logic [7:0] alpha_pow(input int unsigned e, input logic [7:0] red);
        logic [7:0] v;
        v = 8'd1;
        for (int unsigned k = 0; k < e % 255; k++) begin
            v = field_mul(v, 8'd2, red);
        end
        return v;
    endfunction

    // parity count after saturation
    function automatic int parity_len();
        return (ecc_cfg > MAX_ECC) ? MAX_ECC : int'(ecc_cfg);
    endfunction

    // generator taps below the leading one, highest degree first
    function automatic void rebuild_generator();
        logic [7:0] g [0:MAX_ECC];
        logic [7:0] r;
        logic [7:0] red;
        int         n;
        n   = parity_len();
        red = poly_cfg[7:0];
        for (int i = 0; i <= MAX_ECC; i++) begin
            g[i] = 8'd0;
        end
        g[0] = 8'd1;
        for (int len = 1; len <= n; len++) begin
            r      = alpha_pow(int'(root_cfg) + len - 1, red);
            g[len] = field_mul(g[len-1], r, red);
            for (int i = len - 1; i >= 1; i--) begin
                g[i] = g[i] ^ field_mul(g[i-1], r, red);
            end
        end
        for (int i = 0; i < MAX_ECC; i++) begin
            gen_taps[i] = (i < n) ? g[i+1] : 8'd0;
        end
    endfunction

    function automatic void reset_predictor();
        ecc_cfg  = ECC_COUNT_RST;
        root_cfg = FIRST_ROOT_RST;
        poly_cfg = FIELD_POLY_RST;
        for (int i = 0; i < MAX_ECC; i++) begin
            parity_sr[i] = 8'd0;
        end
        rebuild_generator();
    endfunction

    // register write; the parity register keeps its contents
    function automatic void write_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [POLY_W-1:0] val);
        case (idx)
            CFG_ECC_COUNT: begin
                ecc_cfg = val[ECC_W-1:0];
            end
            CFG_FIRST_ROOT: begin
                root_cfg = val[ROOT_W-1:0];
            end
            CFG_FIELD_POLY: begin
                poly_cfg = val;
            end
            default: begin
                return;
            end
        endcase
        rebuild_generator();
    endfunction

    // lfsr step for one message symbol, then the parity drain on end of message
    function automatic void encode_symbol(input rspe_in_t sym);
        logic [7:0] fb;
        logic [7:0] nxt;
        rspe_out_t  res;
        int         n;
        n = parity_len();
        if (n > 0) begin
            fb = sym.data_byte ^ parity_sr[0];
            for (int k = 0; k < n; k++) begin
                nxt = (k + 1 < n) ? parity_sr[k+1] : 8'd0;
                parity_sr[k] = nxt ^ field_mul(gen_taps[k], fb, poly_cfg[7:0]);
            end
        end
        res.out_byte  = sym.data_byte;
        res.is_parity = 1'b0;
        res.last_out  = sym.end_of_message && (n == 0);
        codeword_q = {codeword_q, res};
        if (sym.end_of_message) begin
            for (int k = 0; k < n; k++) begin
                res.out_byte  = parity_sr[k];
                res.is_parity = 1'b1;
                res.last_out  = (k == n - 1);
                codeword_q = {codeword_q, res};
            end
            for (int k = 0; k < MAX_ECC; k++) begin
                parity_sr[k] = 8'd0;
            end
            messages_done++;
        end
    endfunction

    // stimulus queue helpers
    task automatic add_symbol(input logic [7:0] b, input logic eom, input logic steady);
        cmd_t c;
        c.kind               = CMD_SYMBOL;
        c.sym.data_byte      = b;
        c.sym.end_of_message = eom;
        c.idx                = '0;
        c.data               = '0;
        c.steady             = steady;
        cmd_q = {cmd_q, c};
        symbols_queued++;
    endtask

    task automatic add_drain();
        cmd_t c;
        c.kind   = CMD_DRAIN;
        c.sym    = '0;
        c.idx    = '0;
        c.data   = '0;
        c.steady = 1'b0;
        cmd_q = {cmd_q, c};
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [POLY_W-1:0] val);
        cmd_t c;
        c.kind   = CMD_WRITE;
        c.sym    = '0;
        c.idx    = idx;
        c.data   = val;
        c.steady = 1'b0;
        cmd_q = {cmd_q, c};
    endtask

    // well-formed message with random content, now and then a pause mid-message
    task automatic add_message(input int len, input logic steady);
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(99) < 3) begin
                add_drain();
            end
            add_symbol(8'($urandom), i == len - 1, steady);
        end
    endtask

    // random register settings, extremes weighted in
    task automatic add_random_settings();
        logic [POLY_W-1:0] v;
        if ($urandom_range(99) < 60) begin
            case ($urandom_range(9))
                0: v = 9'd0;
                1: v = 9'd1;
                2: v = 9'd32;
                3: v = 9'($urandom_range(63, 33));
                default: v = 9'($urandom_range(31, 2));
            endcase
            // upper bits above the register width are dropped by the block
            v[POLY_W-1:ECC_W] = 3'($urandom);
            add_write(CFG_ECC_COUNT, v);
        end
        if ($urandom_range(99) < 60) begin
            case ($urandom_range(5))
                0: v = 9'd0;
                1: v = 9'd254;
                2: v = 9'd255;
                default: v = 9'($urandom_range(255));
            endcase
            v[POLY_W-1] = 1'($urandom);
            add_write(CFG_FIRST_ROOT, v);
        end
        if ($urandom_range(99) < 60) begin
            case ($urandom_range(9))
                0: v = 9'd256;
                1: v = 9'd511;
                2: v = 9'($urandom_range(255));
                default: v = 9'($urandom_range(511, 256));
            endcase
            add_write(CFG_FIELD_POLY, v);
        end
        if ($urandom_range(99) < 10) begin
            add_write(CFG_UNUSED, 9'($urandom));
        end
    endtask

    // sender: predicts on acceptance, then takes the next command from the queue
    always @(posedge aclk) begin : driver
        cmd_t                 head;
        logic                 nxt_s_valid;
        logic                 nxt_cfg_valid;
        rspe_in_t             nxt_payload;
        logic [CFG_IDX_W-1:0] nxt_idx;
        logic [POLY_W-1:0]    nxt_data;
        if (!aresetn) begin
            reset_predictor();
            s_valid    <= 1'b0;
            cfg_valid  <= 1'b0;
            settle_cnt <= 0;
        end else begin
            nxt_s_valid   = s_valid;
            nxt_payload   = s_payload;
            nxt_cfg_valid = cfg_valid;
            nxt_idx       = cfg_index;
            nxt_data      = cfg_data;
            if (s_valid && s_ready) begin
                encode_symbol(s_payload);
                symbols_sent++;
                nxt_s_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                write_setting(cfg_index, cfg_data);
                writes_done++;
                nxt_cfg_valid = 1'b0;
            end
            if (settle_cnt != 0) begin
                settle_cnt <= settle_cnt - 1;
            end else if (!nxt_s_valid && !nxt_cfg_valid && cmd_q.size() != 0) begin
                head = cmd_q[0];
                case (head.kind)
                    CMD_SYMBOL: begin
                        if (head.steady || $urandom_range(99) >= IDLE_PCT) begin
                            void'(cmd_q.pop_front());
                            nxt_s_valid = 1'b1;
                            nxt_payload = head.sym;
                            steady_now <= head.steady;
                        end
                    end
                    CMD_WRITE: begin
                        void'(cmd_q.pop_front());
                        nxt_cfg_valid = 1'b1;
                        nxt_idx       = head.idx;
                        nxt_data      = head.data;
                    end
                    default: begin
                        // hold off until every expected symbol has left the block
                        if (codeword_q.size() == 0) begin
                            void'(cmd_q.pop_front());
                            settle_cnt <= SETTLE_CYCLES;
                        end
                    end
                endcase
            end
            s_valid   <= nxt_s_valid;
            s_payload <= nxt_payload;
            cfg_valid <= nxt_cfg_valid;
            cfg_index <= nxt_idx;
            cfg_data  <= nxt_data;
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // receiver: compares each accepted item with the oldest expectation
    always @(posedge aclk) begin : monitor
        rspe_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (codeword_q.size() == 0) begin
                    $error("unexpected result item out_byte 0x%0h", m_payload.out_byte);
                    mismatch_cnt++;
                end else begin
                    want = codeword_q.pop_front();
                    check_field("out_byte", want.out_byte, m_payload.out_byte);
                    check_field("is_parity", want.is_parity, m_payload.is_parity);
                    check_field("last_out", want.last_out, m_payload.last_out);
                    results_checked++;
                    if (want.is_parity) begin
                        parity_checked++;
                    end
                end
            end
            m_ready <= steady_now || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // run limit
    initial begin
        #(4_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int phase;
        int rnd_start;

        // extremes of the data byte, then a one-symbol message
        add_symbol(8'h00, 1'b0, 1'b0);
        add_symbol(8'hFF, 1'b0, 1'b0);
        add_symbol(8'h80, 1'b0, 1'b0);
        add_symbol(8'h01, 1'b1, 1'b0);
        add_symbol(8'hA5, 1'b1, 1'b0);

        // no parity at all: plain pass-through
        add_drain();
        add_write(CFG_ECC_COUNT, 9'd0);
        add_symbol(8'h55, 1'b0, 1'b0);
        add_symbol(8'hAA, 1'b1, 1'b0);

        // count above the limit saturates, root at the top, unknown index ignored
        add_drain();
        add_write(CFG_ECC_COUNT, 9'd63);
        add_write(CFG_FIRST_ROOT, 9'd254);
        add_write(CFG_UNUSED, 9'h1FF);
        add_symbol(8'h3C, 1'b0, 1'b0);
        add_symbol(8'hC3, 1'b0, 1'b0);
        add_symbol(8'h7E, 1'b1, 1'b0);

        // polynomial without x^8 and non-primitive, single parity symbol
        add_drain();
        add_write(CFG_FIELD_POLY, 9'h0FF);
        add_write(CFG_ECC_COUNT, 9'd1);
        add_write(CFG_FIRST_ROOT, 9'd1);
        add_symbol(8'hFE, 1'b0, 1'b0);
        add_symbol(8'h81, 1'b1, 1'b0);

        // largest polynomial, full parity count, root exponent wrapping to zero
        add_drain();
        add_write(CFG_FIELD_POLY, 9'h1FF);
        add_write(CFG_ECC_COUNT, 9'd32);
        add_write(CFG_FIRST_ROOT, 9'd255);
        add_symbol(8'h12, 1'b0, 1'b0);
        add_symbol(8'hED, 1'b1, 1'b0);

        // settings changed in the middle of a message
        add_drain();
        add_write(CFG_FIELD_POLY, 9'd285);
        add_write(CFG_ECC_COUNT, 9'd8);
        add_symbol(8'h40, 1'b0, 1'b0);
        add_symbol(8'h02, 1'b0, 1'b0);
        add_symbol(8'hB7, 1'b0, 1'b0);
        add_drain();
        add_write(CFG_FIRST_ROOT, 9'd7);
        add_symbol(8'h9D, 1'b0, 1'b0);
        add_symbol(8'h6B, 1'b1, 1'b0);

        // random phases: settings, then a few messages
        rnd_start = symbols_queued;
        phase = 0;
        while (symbols_queued - rnd_start < RANDOM_SYMBOLS) begin
            add_drain();
            add_random_settings();
            repeat ($urandom_range(5, 2)) begin
                if ($urandom_range(99) < 12) begin
                    // loose symbols with random end marks
                    repeat ($urandom_range(12, 1)) begin
                        add_symbol(8'($urandom), $urandom_range(2) == 0, phase == 3);
                    end
                end else if ($urandom_range(99) < 8) begin
                    add_message($urandom_range(80, 40), phase == 3);
                end else begin
                    add_message($urandom_range(20, 1), phase == 3);
                end
            end
            phase++;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_valid || cfg_valid || codeword_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        if (codeword_q.size() != 0) begin
            $error("%0d expected result items never arrived", codeword_q.size());
            mismatch_cnt++;
        end
        $display("sent %0d symbols in %0d messages across %0d register writes",
                 symbols_sent, messages_done, writes_done);
        $display("checked %0d result items, %0d of them parity", results_checked,
                 parity_checked);
        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
